[rtl/bcds_pkg.sv]
// Shared types and constants for the bus clock divider search core.
// Used by bus_clock_divider_search_core; no other dependencies.
package bcds_pkg;

   localparam int unsigned DIV_W = 32;
   localparam int unsigned CNT_W = 5;

   localparam logic [31:0] PRESCALE_HZ = 32'd20000000;
   localparam logic [31:0] ROUND_MHZ   = 32'd500000;
   localparam logic [31:0] ONE_MHZ     = 32'd1000000;
   localparam logic [21:0] RISE_MULT   = 22'd285;
   localparam logic [21:0] RISE_HALF   = 22'd500;
   localparam logic [31:0] RISE_DIV    = 32'd1000;
   localparam logic [11:0] FINE_BASE   = 12'd20;
   localparam logic [21:0] TARGET_RST  = 22'd100000;

   localparam logic [1:0] REG_WIDE_PRESCALER = 2'd0;
   localparam logic [1:0] REG_TARGET_SPEED   = 2'd1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TOO_FAST = 2'd1;
   localparam logic [1:0] STATUS_NO_STEP  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_RSP
   } state_type;

   typedef enum logic [2:0] {
      PH_PRE,
      PH_INT,
      PH_RISE1,
      PH_RISE2,
      PH_SPEED
   } phase_type;

endpackage

[rtl/bus_clock_divider_search_core.sv]
// Bus clock divider search core: prescaler, internal clock, rise term, fine step search.
// Depends on bcds_pkg; one shared 32-bit restoring divider under a small sequencer.
// Sequence: 4 setup divisions (prescaler, internal clock, two for the rise term), then up to
// FINE_STEPS fine step search divisions; a too-fast request ends after the prescaler division.
// Throughput: one item at a time; req_ready returns the cycle after the result transfer.
// Reset: synchronous, active high; wide_prescaler to 0, target_speed_hz to 100000.
module bus_clock_divider_search_core
   import bcds_pkg::*;
#(
   parameter int unsigned FINE_STEPS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_clock_rate_hz,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_prescaler,
   output logic [5:0]  rsp_fine_divider,
   output logic [8:0]  rsp_divider_word,
   output logic [31:0] rsp_achieved_speed_hz,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [21:0] csr_wdata
);

   localparam int unsigned KW = (FINE_STEPS > 1) ? $clog2(FINE_STEPS) : 1;
   localparam logic [KW-1:0] K_LAST = KW'(FINE_STEPS - 1);

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] divisor_ff, divisor_in;
   logic [31:0]      clk_ff, clk_in;
   logic [2:0]       pre_ff, pre_in;
   logic [31:0]      internal_ff, internal_in;
   logic [11:0]      rise_ff, rise_in;
   logic [KW-1:0]    k_ff, k_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [2:0]       rsp_pre_ff, rsp_pre_in;
   logic [5:0]       rsp_fine_ff, rsp_fine_in;
   logic [8:0]       rsp_word_ff, rsp_word_in;
   logic [31:0]      rsp_speed_ff, rsp_speed_in;

   logic             wide_ff;
   logic [21:0]      target_ff;

   logic [DIV_W:0]   trial;
   logic [DIV_W+1:0] diff;
   logic             ge;
   logic [DIV_W-1:0] q_fin;
   logic             too_big;
   logic [21:0]      rise_prod;
   logic [KW-1:0]    k_next;
   logic [5:0]       k6;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = {1'b0, trial} - {2'b00, divisor_ff};
      ge      = ~diff[DIV_W+1];
      q_fin   = {quo_ff[DIV_W-2:0], ge};
      too_big = wide_ff ? (q_fin >= 32'd8) : (q_fin >= 32'd4);
      rise_prod = 22'(q_fin[12:0]) * RISE_MULT;
      k_next  = k_ff + KW'(1);
      k6      = 6'(k_ff);
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      divisor_in    = divisor_ff;
      clk_in        = clk_ff;
      pre_in        = pre_ff;
      internal_in   = internal_ff;
      rise_in       = rise_ff;
      k_in          = k_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pre_in    = rsp_pre_ff;
      rsp_fine_in   = rsp_fine_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_speed_in  = rsp_speed_ff;
      req_ready     = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               clk_in     = req_clock_rate_hz;
               quo_in     = req_clock_rate_hz;
               rem_in     = '0;
               divisor_in = PRESCALE_HZ;
               count_in   = '0;
               phase_in   = PH_PRE;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in   = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_in   = q_fin;
            count_in = count_ff + CNT_W'(1);
            if (count_ff == '1) begin
               rem_in   = '0;
               count_in = '0;
               case (phase_ff)
                  PH_PRE: begin
                     if (too_big) begin
                        rsp_status_in = STATUS_TOO_FAST;
                        rsp_pre_in    = '0;
                        rsp_fine_in   = '0;
                        rsp_word_in   = '0;
                        rsp_speed_in  = '0;
                        rsp_valid_in  = 1'b1;
                        state_in      = ST_RSP;
                     end else begin
                        pre_in     = q_fin[2:0];
                        quo_in     = clk_ff;
                        divisor_in = 32'(q_fin[2:0]) + 32'd1;
                        phase_in   = PH_INT;
                     end
                  end
                  PH_INT: begin
                     internal_in = q_fin;
                     quo_in      = q_fin + ROUND_MHZ;
                     divisor_in  = ONE_MHZ;
                     phase_in    = PH_RISE1;
                  end
                  PH_RISE1: begin
                     quo_in     = 32'(rise_prod + RISE_HALF);
                     divisor_in = RISE_DIV;
                     phase_in   = PH_RISE2;
                  end
                  PH_RISE2: begin
                     rise_in    = q_fin[11:0];
                     k_in       = '0;
                     quo_in     = internal_ff;
                     divisor_in = 32'(FINE_BASE + q_fin[11:0]);
                     phase_in   = PH_SPEED;
                  end
                  PH_SPEED: begin
                     if (q_fin <= 32'(target_ff)) begin
                        rsp_status_in = STATUS_OK;
                        rsp_pre_in    = pre_ff;
                        rsp_fine_in   = k6;
                        rsp_word_in   = wide_ff ? ({k6, 3'b000} | {6'd0, pre_ff})
                                                : ({1'b0, k6, 2'b00} | {6'd0, pre_ff});
                        rsp_speed_in  = q_fin;
                        rsp_valid_in  = 1'b1;
                        state_in      = ST_RSP;
                     end else if (k_ff == K_LAST) begin
                        rsp_status_in = STATUS_NO_STEP;
                        rsp_pre_in    = pre_ff;
                        rsp_fine_in   = '0;
                        rsp_word_in   = '0;
                        rsp_speed_in  = '0;
                        rsp_valid_in  = 1'b1;
                        state_in      = ST_RSP;
                     end else begin
                        k_in       = k_next;
                        quo_in     = internal_ff;
                        divisor_in = 32'(FINE_BASE + (12'(k_next) << 3) + rise_ff);
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_RSP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_PRE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      divisor_ff    <= divisor_in;
      clk_ff        <= clk_in;
      pre_ff        <= pre_in;
      internal_ff   <= internal_in;
      rise_ff       <= rise_in;
      k_ff          <= k_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pre_ff    <= rsp_pre_in;
      rsp_fine_ff   <= rsp_fine_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_speed_ff  <= rsp_speed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff   <= 1'b0;
         target_ff <= TARGET_RST;
      end else if (csr_we) begin
         if (csr_index == REG_WIDE_PRESCALER) begin
            wide_ff <= csr_wdata[0];
         end else if (csr_index == REG_TARGET_SPEED) begin
            target_ff <= csr_wdata;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_prescaler         = rsp_pre_ff;
   assign rsp_fine_divider      = rsp_fine_ff;
   assign rsp_divider_word      = rsp_word_ff;
   assign rsp_achieved_speed_hz = rsp_speed_ff;

`ifndef SYNTHESIS
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req_ready high while a result is pending");

   a_too_fast_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_TOO_FAST) |->
         (rsp_prescaler == 3'd0 && rsp_divider_word == 9'd0
          && rsp_achieved_speed_hz == 32'd0))
      else $error("too-fast result carries nonzero fields");

   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && count_ff != '1) |=> (state_ff == ST_DIV))
      else $error("division left before its last step");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DIV && phase_ff == PH_PRE
                                    && count_ff == '0))
      else $error("accepted transfer did not start the prescaler division");
`endif

endmodule
